/* design/swop_pkg.sv */
// Shared types and helpers for the sloped wall offset point generator.
// Used by swop_front, swop_fifo, swop_back and the top level.
`default_nettype none
package swop_pkg;

  // Width of the point index carried with each job (covers up to 65536 points).
  localparam int unsigned K_W = 16;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WALL_THICKNESS = 3'd0,
    REG_WALL_HEIGHT    = 3'd1,
    REG_BASE_HEIGHT    = 3'd2,
    REG_SLOPE_ENABLE   = 3'd3,
    REG_SLOPE_RISE     = 3'd4,
    REG_SLOPE_UPWARD   = 3'd5,
    REG_POINT_COUNT    = 3'd6
  } reg_idx_e;

  // One offset job: centre point, tangent, lift index and end-of-curve flag.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [K_W-1:0]     k;
    logic               last;
  } job_t;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic [30:0]        wt;
    logic [30:0]        wh;
    logic signed [31:0] base;
    logic               slope_en;
    logic [30:0]        rise;
    logic               up;
    logic [K_W-1:0]     span;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_MUL,
    ST_DLD,
    ST_DIV,
    ST_DONE
  } st_e;

  typedef enum logic [1:0] {
    PH_X,
    PH_Y,
    PH_L
  } ph_e;

  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -34'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/swop_fifo.sv */
// Short job queue between the front end and the back end.
// Depends on swop_pkg for the job type.
`default_nettype none
module swop_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  swop_pkg::job_t   job_i,
  output logic             full_o,
  input  wire              pop_i,
  output swop_pkg::job_t   job_o,
  output logic             empty_o
);
  import swop_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned AW = $clog2(Depth);

  job_t        mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* design/swop_front.sv */
// Front end: accepts points, tracks the curve position and issues offset jobs.
// Depends on swop_pkg for the job type.
`default_nettype none
module swop_front #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [63:0]                       s_axis_tdata,
  input  wire  [$clog2(MAX_POINTS+1)-1:0]   cnt_i,
  output logic                              push_o,
  output swop_pkg::job_t                    job_o,
  input  wire                               full_i
);
  import swop_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS+1);

  logic signed [31:0] px, py;
  logic signed [31:0] prev_x_q, prev_y_q, held_x_q, held_y_q;
  logic signed [31:0] prev_x_d, prev_y_d, held_x_d, held_y_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               pend_q, pend_d;
  job_t               pend_job_q, pend_job_d;
  job_t               job_a;
  logic               acc, push_a;
  logic [CNT_W-1:0]   span;

  assign px   = s_axis_tdata[31:0];
  assign py   = s_axis_tdata[63:32];
  assign span = cnt_i - 1'b1;

  assign s_axis_tready = !pend_q && !full_i;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    prev_x_d   = prev_x_q;
    prev_y_d   = prev_y_q;
    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_job_d = pend_job_q;
    push_a     = 1'b0;
    job_a      = '0;
    if (pend_q && !full_i) pend_d = 1'b0;
    if (acc) begin
      if (idx_q == '0) begin
        if (cnt_i == CNT_W'(1)) begin
          // A single-point curve has no tangent, so inner and outer coincide.
          push_a     = 1'b1;
          job_a.cx   = px;
          job_a.cy   = py;
          job_a.last = 1'b1;
        end else begin
          held_x_d = px;
          held_y_d = py;
          idx_d    = IDX_W'(1);
        end
      end else begin
        push_a   = 1'b1;
        job_a.cx = held_x_q;
        job_a.cy = held_y_q;
        job_a.k  = K_W'(idx_q - 1'b1);
        if (idx_q == IDX_W'(1)) begin
          job_a.dx = 33'(px) - 33'(held_x_q);
          job_a.dy = 33'(py) - 33'(held_y_q);
        end else begin
          job_a.dx = 33'(px) - 33'(prev_x_q);
          job_a.dy = 33'(py) - 33'(prev_y_q);
        end
        if (CNT_W'(idx_q) >= span) begin
          pend_d          = 1'b1;
          pend_job_d.cx   = px;
          pend_job_d.cy   = py;
          pend_job_d.dx   = 33'(px) - 33'(held_x_q);
          pend_job_d.dy   = 33'(py) - 33'(held_y_q);
          pend_job_d.k    = K_W'(span);
          pend_job_d.last = 1'b1;
          idx_d           = '0;
        end else begin
          prev_x_d = held_x_q;
          prev_y_d = held_y_q;
          held_x_d = px;
          held_y_d = py;
          idx_d    = idx_q + 1'b1;
        end
      end
    end
  end

  assign push_o = push_a || (pend_q && !full_i);
  assign job_o  = push_a ? job_a : pend_job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      held_x_q <= '0;
      held_y_q <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      held_x_q <= held_x_d;
      held_y_q <= held_y_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_job_q <= pend_job_d;
  end

endmodule
`default_nettype wire

/* design/swop_back.sv */
// Back end: normalises each tangent with a serial square root and a shared
// serial divider, computes the slope lift and holds the word for output.
// Depends on swop_pkg for job, configuration and state types.
`default_nettype none
module swop_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  swop_pkg::cfg_t   cfg_i,
  input  wire              empty_i,
  input  swop_pkg::job_t   job_i,
  output logic             pop_o,
  output logic             m_axis_tvalid,
  input  wire              m_axis_tready,
  output logic [191:0]     m_axis_tdata,
  output logic             m_axis_tlast
);
  import swop_pkg::*;

  st_e  st_q, st_d;
  ph_e  ph_q;
  job_t job_q;
  logic [30:0] ax_q, ay_q;
  logic [63:0] prod_q, acc_q;
  logic [63:0] v_q, r_q, b_q;
  logic [31:0] len_q;
  logic [4:0]  step_q;
  logic [32:0] rem_q, div_q;
  logic [31:0] nq_q;
  logic [31:0] mx_q, my_q, lift_q;
  logic        out_v_q;
  logic [191:0] out_data_q;
  logic        out_last_q;

  logic [32:0] ax0, ay0, ax1, ay1;
  logic        lift_on, out_load, div_ge, sq_ge;
  logic [K_W-1:0] kmin, kc;
  logic [31:0] mul_a, mul_b;
  logic [63:0] rb, num;
  logic [33:0] trial;
  logic signed [32:0] ox, oy;
  logic signed [33:0] lift_s;

  assign lift_on = cfg_i.slope_en && (cfg_i.span != '0);
  assign kmin = (job_q.k > cfg_i.span) ? cfg_i.span : job_q.k;
  assign kc   = cfg_i.up ? kmin : cfg_i.span - kmin;

  // Magnitudes of the tangent, shifted together until both fit in 31 bits.
  always_comb begin
    ax0 = job_i.dx[32] ? 33'(-job_i.dx) : 33'(job_i.dx);
    ay0 = job_i.dy[32] ? 33'(-job_i.dy) : 33'(job_i.dy);
    if (ax0[32] || ay0[32]) begin
      ax1 = ax0 >> 2;
      ay1 = ay0 >> 2;
    end else if (ax0[31] || ay0[31]) begin
      ax1 = ax0 >> 1;
      ay1 = ay0 >> 1;
    end else begin
      ax1 = ax0;
      ay1 = ay0;
    end
  end

  always_comb begin
    case (ph_q)
      PH_X:    mul_a = {1'b0, ax_q};
      PH_Y:    mul_a = {1'b0, ay_q};
      default: mul_a = 32'(kc);
    endcase
    mul_b = (ph_q == PH_L) ? {1'b0, cfg_i.rise} : {1'b0, cfg_i.wt};
  end

  assign rb    = r_q + b_q;
  assign sq_ge = (v_q >= rb);
  assign trial = {rem_q, nq_q[31]};
  assign div_ge = (trial >= {1'b0, div_q});
  assign num = (ph_q == PH_L) ? ({prod_q[62:0], 1'b0} + 64'(cfg_i.span))
                              : (prod_q + 64'(len_q));

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (!empty_i) st_d = ST_SQX;
      ST_SQX:  st_d = ST_SQY;
      ST_SQY:  st_d = ST_SUM;
      ST_SUM: begin
        if (ax_q == '0 && ay_q == '0) st_d = lift_on ? ST_MUL : ST_DONE;
        else st_d = ST_SQRT;
      end
      ST_SQRT: if (step_q == '0) st_d = ST_MUL;
      ST_MUL:  st_d = ST_DLD;
      ST_DLD:  st_d = ST_DIV;
      ST_DIV: begin
        if (step_q == '0) begin
          case (ph_q)
            PH_X:    st_d = ST_MUL;
            PH_Y:    st_d = lift_on ? ST_MUL : ST_DONE;
            default: st_d = ST_DONE;
          endcase
        end
      end
      ST_DONE: if (!out_v_q || m_axis_tready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (st_q)
      ST_IDLE: pop_o = !empty_i;
      ST_DONE: out_load = !out_v_q || m_axis_tready;
      default: begin
        pop_o    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_load) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        job_q  <= job_i;
        ax_q   <= ax1[30:0];
        ay_q   <= ay1[30:0];
        mx_q   <= '0;
        my_q   <= '0;
        lift_q <= '0;
      end
      ST_SQX: prod_q <= 64'(ax_q) * 64'(ax_q);
      ST_SQY: begin
        acc_q  <= prod_q;
        prod_q <= 64'(ay_q) * 64'(ay_q);
      end
      ST_SUM: begin
        v_q    <= acc_q + prod_q;
        r_q    <= '0;
        b_q    <= 64'h4000_0000_0000_0000;
        step_q <= 5'd31;
        ph_q   <= (ax_q == '0 && ay_q == '0) ? PH_L : PH_X;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          v_q <= v_q - rb;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q    <= b_q >> 2;
        step_q <= step_q - 1'b1;
        if (step_q == '0) len_q <= sq_ge ? 32'((r_q >> 1) + b_q) : 32'(r_q >> 1);
      end
      ST_MUL: prod_q <= 64'(mul_a) * 64'(mul_b);
      ST_DLD: begin
        rem_q  <= {1'b0, num[63:32]};
        nq_q   <= num[31:0];
        div_q  <= (ph_q == PH_L) ? 33'({cfg_i.span, 1'b0}) : {len_q, 1'b0};
        step_q <= 5'd31;
      end
      ST_DIV: begin
        rem_q  <= div_ge ? 33'(trial - {1'b0, div_q}) : trial[32:0];
        nq_q   <= {nq_q[30:0], div_ge};
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          case (ph_q)
            PH_X: begin
              mx_q <= {nq_q[30:0], div_ge};
              ph_q <= PH_Y;
            end
            PH_Y: begin
              my_q <= {nq_q[30:0], div_ge};
              ph_q <= PH_L;
            end
            default: lift_q <= {nq_q[30:0], div_ge};
          endcase
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_q[31:0]    <= sat34(34'(job_q.cx) - 34'(oy));
      out_data_q[63:32]   <= sat34(34'(job_q.cy) + 34'(ox));
      out_data_q[95:64]   <= sat34(34'(job_q.cx) + 34'(oy));
      out_data_q[127:96]  <= sat34(34'(job_q.cy) - 34'(ox));
      out_data_q[159:128] <= sat34(34'(cfg_i.base) + lift_s);
      out_data_q[191:160] <= sat34(34'(cfg_i.base) + lift_s + 34'($signed({1'b0, cfg_i.wh})));
      out_last_q          <= job_q.last;
    end
  end

  assign ox = job_q.dx[32] ? -$signed({1'b0, mx_q}) : $signed({1'b0, mx_q});
  assign oy = job_q.dy[32] ? -$signed({1'b0, my_q}) : $signed({1'b0, my_q});
  assign lift_s = $signed({2'b00, lift_q});

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

/* design/sloped_wall_offset_points.sv */
// Sloped wall offset points: turns a polyline into wall vertices.
// Input stream: one point per word, tdata = {point_y, point_x}, signed Q16.16.
// Output stream: one vertex set per word, tdata from the lowest bit up holds
// inner_x, inner_y, outer_x, outer_y, z_bottom, z_top; tlast marks the result
// for the final point of a curve.
// Each result appears one point late; the last point of a curve gives two
// results. A job is worked as a 32-step square root and three 32-step divisions
// (two without slope) on one shared serial divider, each division with a multiply
// and a load state, plus set-up states for the squares and their sum and an output
// state. A zero tangent skips the root and the offset divisions.
// A four-entry job queue sits between the point tracker and the arithmetic,
// so points are taken while earlier jobs are still being worked.
// If the receiver stalls, the finished word waits in the output register and
// the next job is computed behind it; input stalls once the queue fills.
// Reset clears the curve position and loads the register defaults.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write it only while idle, as the block itself does not enforce this.
`default_nettype none
module sloped_wall_offset_points #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [63:0]  s_axis_tdata,   // point_x, point_y
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [191:0] m_axis_tdata,   // inner_x, inner_y, outer_x, outer_y, z_bottom, z_top
  output logic         m_axis_tlast,
  input  wire          cfg_we_i,
  input  wire  [2:0]   cfg_idx_i,
  input  wire  [31:0]  cfg_data_i
);
  import swop_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS+1);

  logic [30:0] wt_q, wh_q, rise_q;
  logic [31:0] base_q;
  logic        slope_en_q, up_q;
  logic [10:0] pc_q;
  logic [CNT_W-1:0] cnt;
  cfg_t cfg;
  logic push_w, full_w, pop_w, empty_w;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q       <= 31'd65536;
      wh_q       <= 31'd65536;
      base_q     <= '0;
      slope_en_q <= 1'b0;
      rise_q     <= '0;
      up_q       <= 1'b1;
      pc_q       <= 11'd65;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WALL_THICKNESS: wt_q       <= cfg_data_i[30:0];
        REG_WALL_HEIGHT:    wh_q       <= cfg_data_i[30:0];
        REG_BASE_HEIGHT:    base_q     <= cfg_data_i;
        REG_SLOPE_ENABLE:   slope_en_q <= cfg_data_i[0];
        REG_SLOPE_RISE:     rise_q     <= cfg_data_i[30:0];
        REG_SLOPE_UPWARD:   up_q       <= cfg_data_i[0];
        REG_POINT_COUNT:    pc_q       <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // A count of zero behaves as one, a count above the maximum as the maximum.
  always_comb begin
    if (pc_q == '0) cnt = CNT_W'(1);
    else if (32'(pc_q) > 32'(MAX_POINTS)) cnt = CNT_W'(MAX_POINTS);
    else cnt = CNT_W'(pc_q);
  end

  always_comb begin
    cfg.wt       = wt_q;
    cfg.wh       = wh_q;
    cfg.base     = base_q;
    cfg.slope_en = slope_en_q;
    cfg.rise     = rise_q;
    cfg.up       = up_q;
    cfg.span     = K_W'(cnt - 1'b1);
  end

  swop_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .cnt_i  (cnt),
    .push_o (push_w),
    .job_o  (job_in),
    .full_i (full_w)
  );

  swop_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (push_w),
    .job_i   (job_in),
    .full_o  (full_w),
    .pop_i   (pop_w),
    .job_o   (job_out),
    .empty_o (empty_w)
  );

  swop_back u_back (
    .clk_i, .rst_ni,
    .cfg_i   (cfg),
    .empty_i (empty_w),
    .job_i   (job_out),
    .pop_o   (pop_w),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_w |-> !full_w) else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_w |-> !empty_w) else $error("job queue read while empty");
  a_stall_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_w |-> !s_axis_tready) else $error("point taken with job queue full");
`endif

endmodule
`default_nettype wire

/* verif/sloped_wall_offset_points_tb.sv */
// Testbench for sloped_wall_offset_points: streams polylines in and checks each vertex set.
// It predicts the wall vertices itself, from its own copy of the curve state and registers.
// Depends on swop_pkg for the register indexes.
`timescale 1ns / 1ps
`default_nettype none
module sloped_wall_offset_points_tb;
  import swop_pkg::*;

  typedef struct packed {
    logic [31:0] ix, iy, ox, oy, zb, zt;
    logic        last;
  } vertex_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  wire           s_axis_tready;
  logic [63:0]   s_axis_tdata = '0;
  wire           m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  wire  [191:0]  m_axis_tdata;   // inner_x, inner_y, outer_x, outer_y, z_bottom, z_top
  wire           m_axis_tlast;
  logic          cfg_we_i = 1'b0;
  logic [2:0]    cfg_idx_i = '0;
  logic [31:0]   cfg_data_i = '0;

  sloped_wall_offset_points dut (.*);

  always #4 clk_i = ~clk_i;

  // Register copies and curve state.
  longint thick, height, base, rise, count_reg;
  bit     slope_on, upward;
  longint prev_x, prev_y, hold_x, hold_y;
  int     pt_idx;

  vertex_t pending[$];
  int   errors = 0, words_sent = 0, words_checked = 0;
  bit   send_idle = 1'b1, recv_idle = 1'b1, hold_off = 1'b0;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic vertex_t wall_vertex(longint cx, longint cy, longint dx, longint dy,
                                          int idx, int cnt, bit last);
    longint unsigned ax, ay, len, mx, my, span, k;
    longint offx = 0, offy = 0, lift = 0;
    vertex_t v;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    while (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
      ax >>= 1;
      ay >>= 1;
    end
    if (ax != 0 || ay != 0) begin
      len = int_root(ax * ax + ay * ay);
      mx = (ax * thick + len) / (2 * len);
      my = (ay * thick + len) / (2 * len);
      offx = dx < 0 ? -longint'(mx) : longint'(mx);
      offy = dy < 0 ? -longint'(my) : longint'(my);
    end
    if (slope_on && cnt > 1) begin
      span = cnt - 1;
      if (idx > span) idx = span;
      k = upward ? idx : span - idx;
      lift = longint'((2 * k * rise + span) / (2 * span));
    end
    v.ix = 32'(sat(cx - offy));
    v.iy = 32'(sat(cy + offx));
    v.ox = 32'(sat(cx + offy));
    v.oy = 32'(sat(cy - offx));
    v.zb = 32'(sat(base + lift));
    v.zt = 32'(sat(base + height + lift));
    v.last = last;
    return v;
  endfunction

  // Appends one expected vertex set to the tail of the queue.
  function automatic void expect_vertex(vertex_t v);
    pending = {pending, v};
  endfunction

  // Advances the curve tracker by one point and queues the vertex sets it releases.
  task automatic track_point(logic [31:0] x, logic [31:0] y);
    longint px, py;
    int cnt, idx;
    px = longint'(signed'(x));
    py = longint'(signed'(y));
    cnt = count_reg == 0 ? 1 : (count_reg > 1024 ? 1024 : int'(count_reg));
    if (pt_idx == 0) begin
      if (cnt == 1) begin
        expect_vertex(wall_vertex(px, py, 0, 0, 0, cnt, 1'b1));
      end else begin
        hold_x = px;
        hold_y = py;
        pt_idx = 1;
      end
      return;
    end
    idx = pt_idx - 1;
    if (idx == 0)
      expect_vertex(wall_vertex(hold_x, hold_y, px - hold_x, py - hold_y, idx, cnt, 1'b0));
    else
      expect_vertex(wall_vertex(hold_x, hold_y, px - prev_x, py - prev_y, idx, cnt, 1'b0));
    if (pt_idx >= cnt - 1) begin
      expect_vertex(wall_vertex(px, py, px - hold_x, py - hold_y, cnt - 1, cnt, 1'b1));
      pt_idx = 0;
      return;
    end
    prev_x = hold_x;
    prev_y = hold_y;
    hold_x = px;
    hold_y = py;
    pt_idx++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_WALL_THICKNESS: thick = val[30:0];
      REG_WALL_HEIGHT:    height = val[30:0];
      REG_BASE_HEIGHT:    base = longint'(signed'(val));
      REG_SLOPE_ENABLE:   slope_on = val[0];
      REG_SLOPE_RISE:     rise = val[30:0];
      REG_SLOPE_UPWARD:   upward = val[0];
      REG_POINT_COUNT:    count_reg = val[10:0];
      default: ;
    endcase
  endtask

  // Sends one point word; called just after a falling edge. Valid and data are
  // driven with blocking writes so back-to-back words can follow in one step.
  task automatic send_point(logic [31:0] x, logic [31:0] y);
    while (send_idle && $urandom_range(99) < 35) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_point(x, y);
    words_sent++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Lets the queue drain, then the arithmetic back end go quiet, before any register write.
  task automatic drain();
    int n = 0;
    while (pending.size() != 0 && n < 2000000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (600) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    write_reg(REG_POINT_COUNT, 4);
    send_point(0, 0);
    send_point(32'h0001_0000, 0);
    send_point(32'h0001_0000, 32'h0001_0000);
    send_point(32'h0002_0000, 32'h0001_0000);
    // Repeated points give a zero tangent.
    send_point(5, 5); send_point(5, 5); send_point(5, 5); send_point(5, 5);
    // Coordinate extremes saturate the offset vertices.
    send_point(32'h7FFF_FFFF, 32'h8000_0000); send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF); send_point(32'h8000_0000, 32'h8000_0000);
    drain();
    write_reg(REG_WALL_THICKNESS, 32'h7FFF_FFFF);
    write_reg(REG_WALL_HEIGHT, 32'h7FFF_FFFF);
    write_reg(REG_BASE_HEIGHT, 32'h7FFF_0000);
    write_reg(REG_SLOPE_ENABLE, 1);
    write_reg(REG_SLOPE_RISE, 32'h7FFF_FFFF);
    write_reg(REG_SLOPE_UPWARD, 0);
    write_reg(REG_POINT_COUNT, 1);
    // Single-point curve: one result per point.
    send_point(1, 2); send_point(32'hFFFF_0000, 3);
    drain();
    write_reg(REG_POINT_COUNT, 0);
    send_point(7, 8);
    drain();
    write_reg(REG_BASE_HEIGHT, 32'h8000_0000);
    write_reg(REG_WALL_THICKNESS, 0);
    write_reg(REG_POINT_COUNT, 2);
    send_point(1, 1); send_point(3, 9);
    drain();
    write_reg(REG_POINT_COUNT, 11'h7FF);
    write_reg(REG_SLOPE_UPWARD, 1);
    for (int i = 0; i < 5; i++) send_point(rand_coord(), rand_coord());
    drain();
    // Shrinking the count mid-curve ends the curve early with a clamped lift index.
    write_reg(REG_POINT_COUNT, 3);
    send_point(9, 9);
    drain();
  endtask

  task automatic test_random();
    int sent = 0, len;
    while (sent < 1880) begin
      drain();
      write_reg(REG_WALL_THICKNESS, $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h40000));
      write_reg(REG_WALL_HEIGHT, $urandom);
      write_reg(REG_BASE_HEIGHT, $urandom_range(1) ? $urandom : $urandom_range(2000) - 1000);
      write_reg(REG_SLOPE_ENABLE, $urandom_range(1));
      write_reg(REG_SLOPE_RISE, $urandom);
      write_reg(REG_SLOPE_UPWARD, $urandom_range(1));
      len = (sent == 0 || (sent < 800 && $urandom_range(9) == 0)) ?
            $urandom_range(1024, 1030) : $urandom_range(1, 20);
      write_reg(REG_POINT_COUNT, len);
      send_idle = (sent % 400) > 80;
      recv_idle = (sent % 400) < 300;
      // A long count gives one whole curve; short counts give whole curves,
      // plus occasionally a stray tail that the loop below finishes.
      if (len > 20) len = 1024;
      else len = len * $urandom_range(1, 3) + ($urandom_range(4) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(3) == 0)
          send_point($urandom, $urandom);
        else
          send_point(rand_coord() & 32'h00FF_FFFF, rand_coord() & 32'h00FF_FFFF);
        sent++;
      end
      // Finish a stray tail so register changes never land mid-curve.
      while (pt_idx != 0) begin
        send_point($urandom, $urandom);
        sent++;
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    write_reg(REG_POINT_COUNT, 30);
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(negedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 30; i++) send_point($urandom, $urandom);
    drain();
  endtask

  // Receiver side: ready toggles at falling edges, words are taken at rising edges.
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && !(recv_idle && $urandom_range(99) < 35);
  end

  always @(posedge clk_i) begin
    vertex_t w, e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      {w.zt, w.zb, w.oy, w.ox, w.iy, w.ix} = m_axis_tdata;
      w.last = m_axis_tlast;
      if (pending.size() == 0) begin
        $display("%0t: vertex word with none expected: %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = pending.pop_front();
        words_checked++;
        if (w != e) begin
          $display("%0t: mismatch expected ix %h iy %h ox %h oy %h zb %h zt %h last %b",
                   $time, e.ix, e.iy, e.ox, e.oy, e.zb, e.zt, e.last);
          $display("%0t:          actual   ix %h iy %h ox %h oy %h zb %h zt %h last %b",
                   $time, w.ix, w.iy, w.ox, w.oy, w.zb, w.zt, w.last);
          errors++;
        end
      end
    end
  end

  initial begin
    thick = 65536; height = 65536; base = 0; slope_on = 0; rise = 0;
    upward = 1; count_reg = 65;
    prev_x = 0; prev_y = 0; hold_x = 0; hold_y = 0; pt_idx = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    $display("Sent %0d points, checked %0d vertex words over curves of 1 to 1024 points,",
             words_sent, words_checked);
    $display("with slope on and off, register extremes and a long receiver hold-off.");
    if (errors == 0 && pending.size() == 0) begin
      $display("PASS");
    end else begin
      if (pending.size() != 0) $display("%0d vertex words never arrived", pending.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout");
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
design/swop_pkg.sv
design/swop_fifo.sv
design/swop_front.sv
design/swop_back.sv
design/sloped_wall_offset_points.sv
verif/sloped_wall_offset_points_tb.sv
